// ----- src/tdpt_pkg.sv -----
// Package for the trial-division prime test: controller state codes and
// output word layout. No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

  // Result word: prime flag in bit 0, zero fill up to one byte
  localparam int OUT_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CHK  = 4'b0100,
    ST_RES  = 4'b1000
  } state_t;

endpackage

// ----- src/trial_division_prime_test.sv -----
// Top level of the trial-division prime test: controller, bit-serial divider,
// output register. Depends on tdpt_pkg.
`timescale 1ns / 1ps

// Takes one unsigned number per word and returns one word with its prime bit
// set when the number is prime (0 and 1 are reported not prime). Divisors 2,
// 3, 4, ... are tried in turn by one restoring divider that brings in one bit
// of the number per cycle, so each trial is NUM_BITS division steps followed
// by one check of quotient and remainder. The run stops at the first exact
// divisor or once the divisor exceeds the quotient. One item is worked at a
// time; a finished result waits in the output register while the next number
// is taken.
module trial_division_prime_test #(
  parameter int NUM_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((NUM_BITS + 7) / 8) * 8-1:0] in_tdata,   // [NUM_BITS-1:0] number
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tdpt_pkg::OUT_W-1:0]          out_tdata   // [0] prime flag
);

  localparam int CW = (NUM_BITS > 2) ? $clog2(NUM_BITS) : 1;

  tdpt_pkg::state_t          state_r, state_nxt;
  logic [NUM_BITS-1:0]       n_r;
  logic [NUM_BITS-1:0]       nsh_r, nsh_nxt;
  logic [NUM_BITS-1:0]       d_r, d_nxt;
  logic [NUM_BITS-1:0]       q_r, q_nxt;
  logic [NUM_BITS:0]         rem_r, rem_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      res_r, res_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic                      out_prime_r, out_prime_nxt;

  logic [NUM_BITS:0]         rem_sh;
  logic                      ge;
  logic                      in_acc;
  logic                      out_free;

  assign in_tready  = (state_r == tdpt_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(tdpt_pkg::OUT_W - 1){1'b0}}, out_prime_r};

  // One restoring step: shift in the next bit of the number, subtract if it fits
  assign rem_sh = {rem_r[NUM_BITS-1:0], nsh_r[NUM_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, d_r});

  always_comb begin
    state_nxt      = state_r;
    nsh_nxt        = nsh_r;
    d_nxt          = d_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_prime_nxt  = out_prime_r;
    unique case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          nsh_nxt = in_tdata[NUM_BITS-1:0];
          d_nxt   = NUM_BITS'(2);
          rem_nxt = '0;
          cnt_nxt = CW'(NUM_BITS - 1);
          if (in_tdata[NUM_BITS-1:1] == '0) begin
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::ST_RES;
          end else begin
            state_nxt = tdpt_pkg::ST_DIV;
          end
        end
      end
      tdpt_pkg::ST_DIV: begin
        rem_nxt = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
        q_nxt   = {q_r[NUM_BITS-2:0], ge};
        nsh_nxt = {nsh_r[NUM_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = tdpt_pkg::ST_CHK;
        end
      end
      tdpt_pkg::ST_CHK: begin
        if (d_r > q_r) begin
          res_nxt   = 1'b1;
          state_nxt = tdpt_pkg::ST_RES;
        end else if (rem_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = tdpt_pkg::ST_RES;
        end else begin
          // next divisor: reload the number and clear the partial remainder
          d_nxt     = d_r + NUM_BITS'(1);
          nsh_nxt   = n_r;
          rem_nxt   = '0;
          cnt_nxt   = CW'(NUM_BITS - 1);
          state_nxt = tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_RES: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_prime_nxt  = res_r;
          state_nxt      = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tdpt_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r <= in_tdata[NUM_BITS-1:0];
    end
    nsh_r       <= nsh_nxt;
    d_r         <= d_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

endmodule

// ----- src/tdpt_chk.sv -----
// Port-level checker for trial_division_prime_test and its bind statement.
// Depends on tdpt_pkg and the top level's port list.
`timescale 1ns / 1ps

module tdpt_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tdpt_pkg::OUT_W-1:0]   out_tdata
);

  // A stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // One number at a time: input closes right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second number taken while one is in work");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tdpt_pkg::OUT_W-1:1] == '0)
    else $error("fill bits of result word not zero");

endmodule

bind trial_division_prime_test tdpt_chk u_tdpt_chk (.*);

// ----- dv/tb_trial_division_prime_test.sv -----
// Testbench for trial_division_prime_test: drives numbers in bursts, stalls the
// result side, predicts each prime flag and checks it. Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

  localparam int NUM_BITS = 31;
  localparam int IN_W = ((NUM_BITS + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 106;
  localparam int MAX_TRIALS = 256;     // keeps random numbers cheap to test
  localparam int PARK_CYCLES = 3000;   // long hold-off on the result side

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;   // [30:0] number
  logic            out_tvalid;
  logic            out_tready;
  logic [tdpt_pkg::OUT_W-1:0] out_tdata; // [0] prime flag

  bit          park_results = 1'b0;
  bit          offering = 1'b0;
  int unsigned burst_left = 0;

  class prime_scoreboard;
    typedef struct {
      bit [NUM_BITS-1:0] number;
      bit                prime;
    } verdict_t;

    verdict_t    verdicts[$];
    int unsigned errors = 0;

    function bit prime_flag(bit [NUM_BITS-1:0] n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [IN_W-1:0] word);
      verdict_t v;
      // bits above the field are padding and must be ignored
      v.number = word[NUM_BITS-1:0];
      v.prime = prime_flag(v.number);
      verdicts.push_back(v);
    endfunction

    function void check_result(logic [tdpt_pkg::OUT_W-1:0] word);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual prime flag %0b",
                 $time, word[0]);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (word[0] !== v.prime) begin
        $display("%0t: prime flag mismatch for number %0d: expected %0b, actual %0b",
                 $time, v.number, v.prime, word[0]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  prime_scoreboard sb;

  trial_division_prime_test #(
    .NUM_BITS(NUM_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_number(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Count divisors up to the square root that the block will try, stopping early past the cap.
  function automatic int unsigned divisor_trials(bit [NUM_BITS-1:0] n, int unsigned cap);
    longint unsigned d;
    int unsigned     count;
    count = 0;
    for (d = 2; d <= n / d; d++) begin
      count++;
      if (n % d == 0 || count > cap) break;
    end
    return count;
  endfunction

  task automatic offer_word(logic [IN_W-1:0] word);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the input until every pending result has come back.
  task automatic drain_results();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_number();
    bit [NUM_BITS-1:0] n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = NUM_BITS'($urandom_range(0, 4095));
      5, 6, 7:       n = NUM_BITS'($urandom_range(0, 65535));
      default: begin
        // full-width values, redrawn until the block can settle them quickly
        n = NUM_BITS'($urandom);
        while (divisor_trials(n, MAX_TRIALS) > MAX_TRIALS) n = NUM_BITS'($urandom);
      end
    endcase
    return IN_W'(n);
  endfunction

  // Result side: stretches of always ready, light stalls and heavy stalls, and a long park when asked.
  initial begin : receiver
    int unsigned left;
    int unsigned mode;
    out_tready <= 1'b0;
    left = 0;
    mode = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (park_results) begin
        out_tready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
        park_results = 1'b0;
        left = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0] directed[$];
    sb = new;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero and one, two and three, small squares, square-bound cases,
    // full-width patterns and padding bits that must be dropped
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd25,
                 32'd49, 32'd97, 32'd121, 32'd8191, 32'd65521, 32'd65535,
                 32'd1018081, 32'd1048573, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
                 32'h5555_5555, 32'h2AAA_AAAA, 32'h8000_0000, 32'h8000_0005,
                 32'hFFFF_FFFE};
    foreach (directed[i]) offer_word(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 40) begin
        // park the result side and keep feeding cheap numbers so input backs up
        park_results = 1'b1;
        repeat (10) offer_word(IN_W'($urandom_range(0, 255)));
      end
      if (i == 90) drain_results();
      offer_word(random_number());
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(200_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
